/* sv/bta_pkg.sv */
package bta_pkg;

    localparam int unsigned POOL_DEPTH = 4096;
    localparam int unsigned ADDR_W     = $clog2(POOL_DEPTH);
    localparam int unsigned LEN_W      = 13;
    localparam int unsigned TAG_W      = LEN_W + 1;
    localparam int unsigned SIZE_W     = 20;
    localparam int unsigned NEED_W     = 19;
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned ST_W       = 2;
    localparam int unsigned MIN_FRAG   = 3;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADIDX  = 2'd2,
        ST_DOUBLE  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_INIT_H, S_INIT_T, S_IDLE, S_START,
        S_A_RD, S_A_CHK, S_SPL_H, S_SPL_T,
        S_F_RD, S_F_CHK, S_L_RD, S_L_CHK, S_R_RD, S_R_CHK,
        S_MRK_H, S_MRK_T, S_RES
    } t_state;

    typedef enum logic [1:0] {
        RD_POS, RD_LEFT, RD_RIGHT
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_INIT_H, WR_INIT_T, WR_SPL_H, WR_SPL_T, WR_MRK_H, WR_MRK_T
    } t_wr_sel;

    typedef struct packed {
        logic    ld_req;
        logic    pos_adv;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    ld_fit;
        logic    ld_found;
        logic    ld_left;
        logic    ld_right;
        logic    st_ld;
        t_status st;
        logic    res_ld;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic size_zero;
        logic uidx_zero;
        logic pos_end;
        logic len_zero;
        logic tag_free;
        logic fits;
        logic split;
        logic at_head;
        logic head_zero;
        logic left_ok;
        logic right_in;
        logic right_ok;
        logic out_free;
    } t_sts;

endpackage

/* sv/bta_req_if.sv */
interface bta_req_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [bta_pkg::SIZE_W-1:0]       size_bytes;
    logic [bta_pkg::IDX_W-1:0]        user_index;

    modport source (output valid, kind, size_bytes, user_index, input ready);
    modport sink   (input valid, kind, size_bytes, user_index, output ready);
endinterface

/* sv/bta_rsp_if.sv */
interface bta_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bta_pkg::ST_W-1:0]         status;
    logic [bta_pkg::IDX_W-1:0]        granted_index;
    logic [bta_pkg::LEN_W-1:0]        granted_words;

    modport source (output valid, status, granted_index, granted_words, input ready);
    modport sink   (input valid, status, granted_index, granted_words, output ready);
endinterface

/* sv/boundary_tag_first_fit_allocator.sv */
// First-fit boundary-tag allocator over up to 4096 words. Each request word walks the
// fragment chain in the tag store, which has one write and one read port, visiting each
// fragment in a read state and a check state. An allocate then writes the tags of the
// split-off remainder if it splits, and marks the grant's head and tail; a free reads
// its left and right neighbours and marks the merged fragment. One request is in
// flight at a time; the result word waits in an output register while the next request
// is taken. After reset or a pool_words write the store gets its single free fragment.
module boundary_tag_first_fit_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bta_pkg::LEN_W-1:0]     i_cfg_data,
    bta_req_if.sink                       i_req,
    bta_rsp_if.source                     o_rsp
);

    bta_pkg::t_cmd cmd;
    bta_pkg::t_sts sts;

    bta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bta_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_req.kind),
        .i_size_bytes    (i_req.size_bytes),
        .i_user_index    (i_req.user_index),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_granted_index (o_rsp.granted_index),
        .o_granted_words (o_rsp.granted_words)
    );

endmodule

/* sv/bta_ctrl.sv */
module bta_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  bta_pkg::t_sts     i_sts,
    output bta_pkg::t_cmd     o_cmd
);

    bta_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bta_pkg::S_INIT_H;
        end else if (i_cfg_we) begin
            r_state <= bta_pkg::S_INIT_H;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = bta_pkg::RD_POS;
        o_cmd.wr_sel = bta_pkg::WR_INIT_H;
        o_cmd.st     = bta_pkg::ST_OK;
        o_req_ready  = 1'b0;
        unique case (r_state)
            bta_pkg::S_INIT_H: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = bta_pkg::WR_INIT_H;
                n_state      = bta_pkg::S_INIT_T;
            end
            bta_pkg::S_INIT_T: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = bta_pkg::WR_INIT_T;
                n_state      = bta_pkg::S_IDLE;
            end
            bta_pkg::S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.ld_req = i_req_valid;
                if (i_req_valid) n_state = bta_pkg::S_START;
            end
            bta_pkg::S_START: begin
                if (!i_sts.kind) begin
                    if (i_sts.size_zero) begin
                        o_cmd.st_ld = 1'b1;
                        o_cmd.st    = bta_pkg::ST_NOSPACE;
                        n_state     = bta_pkg::S_RES;
                    end else begin
                        n_state = bta_pkg::S_A_RD;
                    end
                end else begin
                    if (i_sts.uidx_zero) begin
                        o_cmd.st_ld = 1'b1;
                        o_cmd.st    = bta_pkg::ST_BADIDX;
                        n_state     = bta_pkg::S_RES;
                    end else begin
                        n_state = bta_pkg::S_F_RD;
                    end
                end
            end
            bta_pkg::S_A_RD: begin
                if (i_sts.pos_end) begin
                    o_cmd.st_ld = 1'b1;
                    o_cmd.st    = bta_pkg::ST_NOSPACE;
                    n_state     = bta_pkg::S_RES;
                end else begin
                    n_state = bta_pkg::S_A_CHK;
                end
            end
            bta_pkg::S_A_CHK: begin
                priority if (i_sts.len_zero) begin
                    o_cmd.st_ld = 1'b1;
                    o_cmd.st    = bta_pkg::ST_NOSPACE;
                    n_state     = bta_pkg::S_RES;
                end else if (i_sts.tag_free && i_sts.fits) begin
                    o_cmd.ld_fit = 1'b1;
                    n_state      = i_sts.split ? bta_pkg::S_SPL_H : bta_pkg::S_MRK_H;
                end else begin
                    o_cmd.pos_adv = 1'b1;
                    n_state       = bta_pkg::S_A_RD;
                end
            end
            bta_pkg::S_SPL_H: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = bta_pkg::WR_SPL_H;
                n_state      = bta_pkg::S_SPL_T;
            end
            bta_pkg::S_SPL_T: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = bta_pkg::WR_SPL_T;
                n_state      = bta_pkg::S_MRK_H;
            end
            bta_pkg::S_F_RD: begin
                if (i_sts.pos_end) begin
                    o_cmd.st_ld = 1'b1;
                    o_cmd.st    = bta_pkg::ST_BADIDX;
                    n_state     = bta_pkg::S_RES;
                end else begin
                    n_state = bta_pkg::S_F_CHK;
                end
            end
            bta_pkg::S_F_CHK: begin
                priority if (i_sts.len_zero) begin
                    o_cmd.st_ld = 1'b1;
                    o_cmd.st    = bta_pkg::ST_BADIDX;
                    n_state     = bta_pkg::S_RES;
                end else if (i_sts.at_head && i_sts.tag_free) begin
                    o_cmd.st_ld = 1'b1;
                    o_cmd.st    = bta_pkg::ST_DOUBLE;
                    n_state     = bta_pkg::S_RES;
                end else if (i_sts.at_head) begin
                    o_cmd.ld_found = 1'b1;
                    n_state        = bta_pkg::S_L_RD;
                end else begin
                    o_cmd.pos_adv = 1'b1;
                    n_state       = bta_pkg::S_F_RD;
                end
            end
            bta_pkg::S_L_RD: begin
                o_cmd.rd_sel = bta_pkg::RD_LEFT;
                n_state      = i_sts.head_zero ? bta_pkg::S_R_RD : bta_pkg::S_L_CHK;
            end
            bta_pkg::S_L_CHK: begin
                o_cmd.ld_left = i_sts.left_ok;
                n_state       = bta_pkg::S_R_RD;
            end
            bta_pkg::S_R_RD: begin
                o_cmd.rd_sel = bta_pkg::RD_RIGHT;
                n_state      = i_sts.right_in ? bta_pkg::S_R_CHK : bta_pkg::S_MRK_H;
            end
            bta_pkg::S_R_CHK: begin
                o_cmd.rd_sel   = bta_pkg::RD_RIGHT;
                o_cmd.ld_right = i_sts.right_ok;
                n_state        = bta_pkg::S_MRK_H;
            end
            bta_pkg::S_MRK_H: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = bta_pkg::WR_MRK_H;
                n_state      = bta_pkg::S_MRK_T;
            end
            bta_pkg::S_MRK_T: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = bta_pkg::WR_MRK_T;
                o_cmd.st_ld  = 1'b1;
                o_cmd.st     = bta_pkg::ST_OK;
                n_state      = bta_pkg::S_RES;
            end
            bta_pkg::S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.res_ld = 1'b1;
                    n_state      = bta_pkg::S_IDLE;
                end
            end
            default: n_state = bta_pkg::S_INIT_H;
        endcase
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bta_pkg::S_IDLE) |-> !o_cmd.wr_en)
        else $error("tag store written while idle");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.ld_req && !i_cfg_we) |=> (r_state == bta_pkg::S_START))
        else $error("accepted word not started");
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !o_cmd.res_ld && !o_cmd.wr_en)
        else $error("ready outside idle");

endmodule

/* sv/bta_dpath.sv */
module bta_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bta_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic                          i_kind,
    input  logic [bta_pkg::SIZE_W-1:0]    i_size_bytes,
    input  logic [bta_pkg::IDX_W-1:0]     i_user_index,
    input  bta_pkg::t_cmd                 i_cmd,
    output bta_pkg::t_sts                 o_sts,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic [bta_pkg::ST_W-1:0]      o_status,
    output logic [bta_pkg::IDX_W-1:0]     o_granted_index,
    output logic [bta_pkg::LEN_W-1:0]     o_granted_words
);

    localparam int unsigned AW = bta_pkg::ADDR_W;
    localparam int unsigned LW = bta_pkg::LEN_W;

    logic [bta_pkg::TAG_W-1:0]  r_mem [bta_pkg::POOL_DEPTH];
    logic [bta_pkg::TAG_W-1:0]  r_rdata;
    logic [LW-1:0]              r_pool;
    logic                       r_kind;
    logic                       r_size_zero;
    logic [bta_pkg::NEED_W-1:0] r_need;
    logic [AW-1:0]              r_head;
    logic [LW-1:0]              r_pos;
    logic [LW-1:0]              r_len;
    logic [LW-1:0]              r_total;
    logic                       r_uidx_zero;
    bta_pkg::t_status           r_st;
    logic                       r_ovalid;
    logic [bta_pkg::ST_W-1:0]   r_ostatus;
    logic [bta_pkg::IDX_W-1:0]  r_oindex;
    logic [LW-1:0]              r_owords;

    logic [LW-1:0]              len;
    logic                       tfree;
    logic [LW-1:0]              right;
    logic [LW:0]                right_end;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [bta_pkg::TAG_W-1:0]  wr_data;
    logic [LW-1:0]              need_l;
    logic [LW-1:0]              base;
    logic [LW-1:0]              pool_clamp;
    logic [bta_pkg::SIZE_W:0]   size_up;

    assign len       = r_rdata[LW-1:0];
    assign tfree     = r_rdata[LW];
    assign right     = {1'b0, r_head} + r_total;
    assign right_end = {1'b0, right} + {1'b0, len};
    assign need_l    = r_need[LW-1:0];
    assign base      = r_kind ? {1'b0, r_head} : r_pos;
    assign size_up   = {1'b0, i_size_bytes} + (bta_pkg::SIZE_W+1)'(3);

    always_comb begin
        priority if (i_cfg_data < LW'(bta_pkg::MIN_FRAG)) pool_clamp = LW'(bta_pkg::MIN_FRAG);
        else if (i_cfg_data > LW'(bta_pkg::POOL_DEPTH)) pool_clamp = LW'(bta_pkg::POOL_DEPTH);
        else pool_clamp = i_cfg_data;
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            bta_pkg::RD_POS:   rd_addr = r_pos[AW-1:0];
            bta_pkg::RD_LEFT:  rd_addr = r_head - AW'(1);
            bta_pkg::RD_RIGHT: rd_addr = right[AW-1:0];
            default:           rd_addr = r_pos[AW-1:0];
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            bta_pkg::WR_INIT_H: begin
                wr_addr = '0;
                wr_data = {1'b1, r_pool};
            end
            bta_pkg::WR_INIT_T: begin
                wr_addr = AW'(r_pool - LW'(1));
                wr_data = {1'b1, r_pool};
            end
            bta_pkg::WR_SPL_H: begin
                wr_addr = AW'(r_pos + need_l);
                wr_data = {1'b1, r_len - need_l};
            end
            bta_pkg::WR_SPL_T: begin
                wr_addr = AW'(r_pos + r_len - LW'(1));
                wr_data = {1'b1, r_len - need_l};
            end
            bta_pkg::WR_MRK_H: begin
                wr_addr = base[AW-1:0];
                wr_data = {r_kind, r_total};
            end
            bta_pkg::WR_MRK_T: begin
                wr_addr = AW'(base + r_total - LW'(1));
                wr_data = {r_kind, r_total};
            end
            default: begin
                wr_addr = '0;
                wr_data = {1'b1, r_pool};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= LW'(bta_pkg::POOL_DEPTH);
        end else if (i_cfg_we) begin
            r_pool <= pool_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_kind      <= i_kind;
            r_size_zero <= (i_size_bytes == '0);
            r_need      <= bta_pkg::NEED_W'(size_up[bta_pkg::SIZE_W:2]) + bta_pkg::NEED_W'(2);
            r_uidx_zero <= (i_user_index == '0);
            r_head      <= i_user_index - AW'(1);
            r_pos       <= '0;
        end
        if (i_cmd.pos_adv) r_pos <= r_pos + len;
        if (i_cmd.ld_fit) begin
            r_len   <= len;
            r_total <= (({6'b0, len} >= r_need + bta_pkg::NEED_W'(bta_pkg::MIN_FRAG)))
                       ? need_l : len;
        end
        if (i_cmd.ld_found) r_total <= len;
        if (i_cmd.ld_left) begin
            r_head  <= r_head - len[AW-1:0];
            r_total <= r_total + len;
        end
        if (i_cmd.ld_right) r_total <= r_total + len;
        if (i_cmd.st_ld) r_st <= i_cmd.st;
    end

    // result word holds until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.res_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_ostatus <= r_st;
            if (!r_kind && r_st == bta_pkg::ST_OK) begin
                r_oindex <= r_pos[bta_pkg::IDX_W-1:0] + bta_pkg::IDX_W'(1);
                r_owords <= r_total;
            end else begin
                r_oindex <= '0;
                r_owords <= '0;
            end
        end
    end

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.size_zero = r_size_zero;
        o_sts.uidx_zero = r_uidx_zero;
        o_sts.pos_end   = r_pos >= r_pool;
        o_sts.len_zero  = len == '0;
        o_sts.tag_free  = tfree;
        o_sts.fits      = {6'b0, len} >= r_need;
        o_sts.split     = {6'b0, len} >= r_need + bta_pkg::NEED_W'(bta_pkg::MIN_FRAG);
        o_sts.at_head   = r_pos == {1'b0, r_head};
        o_sts.head_zero = r_head == '0;
        o_sts.left_ok   = tfree && len != '0 && len <= {1'b0, r_head};
        o_sts.right_in  = right < r_pool;
        o_sts.right_ok  = tfree && len != '0 && right_end <= {1'b0, r_pool};
        o_sts.out_free  = !r_ovalid || i_rsp_ready;
    end

    assign o_rsp_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_granted_index = r_oindex;
    assign o_granted_words = r_owords;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_ld |-> (!r_ovalid || i_rsp_ready))
        else $error("result word overwritten");
    a_grant_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_owords != '0) |-> (r_owords >= LW'(bta_pkg::MIN_FRAG)))
        else $error("grant below minimum fragment");
    a_pool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg_we) |-> (r_pool >= LW'(bta_pkg::MIN_FRAG)
                             && r_pool <= LW'(bta_pkg::POOL_DEPTH)))
        else $error("pool size out of range");

endmodule

/* tb/bta_tb_if.sv */
`timescale 1ns / 1ps

interface bta_cfg_if;
    logic                        we;
    logic [bta_pkg::LEN_W-1:0]   data;
endinterface

/* tb/bta_checker.sv */
`timescale 1ns / 1ps

module bta_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bta_pkg::LEN_W-1:0]   i_cfg_data,
    bta_req_if                          req,
    bta_rsp_if                          rsp,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_rsp_count
);

    typedef struct packed {
        bta_pkg::t_status                status;
        logic [bta_pkg::IDX_W-1:0]       gidx;
        logic [bta_pkg::LEN_W-1:0]       gwords;
    } t_grant;

    logic [bta_pkg::TAG_W-1:0] tags [bta_pkg::POOL_DEPTH];
    int unsigned      pool_eff;
    t_grant           grants_due [$];
    int               fail_count = 0;
    int               rsp_count = 0;

    function automatic int unsigned tlen(int unsigned pos);
        return (pos >= bta_pkg::POOL_DEPTH) ? 0 : int'(tags[pos][bta_pkg::LEN_W-1:0]);
    endfunction

    function automatic bit tfree(int unsigned pos);
        return (pos >= bta_pkg::POOL_DEPTH) ? 1'b0 : tags[pos][bta_pkg::LEN_W];
    endfunction

    function automatic void mark(int unsigned head, int unsigned len, bit fr);
        if (head < bta_pkg::POOL_DEPTH) tags[head] = {fr, len[bta_pkg::LEN_W-1:0]};
        if (len > 0 && head + len - 1 < bta_pkg::POOL_DEPTH)
            tags[head + len - 1] = {fr, len[bta_pkg::LEN_W-1:0]};
    endfunction

    function automatic void rebuild(logic [bta_pkg::LEN_W-1:0] words);
        int unsigned p;
        p = words;
        if (p < bta_pkg::MIN_FRAG) p = bta_pkg::MIN_FRAG;
        if (p > bta_pkg::POOL_DEPTH) p = bta_pkg::POOL_DEPTH;
        pool_eff = p;
        foreach (tags[i]) tags[i] = '0;
        mark(0, p, 1'b1);
    endfunction

    function automatic t_grant allocate(logic [bta_pkg::SIZE_W-1:0] size);
        t_grant g;
        int unsigned need, pos, len, grant;
        g = '{status: bta_pkg::ST_NOSPACE, gidx: '0, gwords: '0};
        if (size == 0) return g;
        need = (int'(size) + 3) / 4 + 2;
        pos = 0;
        while (pos < pool_eff) begin
            len = tlen(pos);
            if (len == 0) break;
            if (tfree(pos) && len >= need) begin
                grant = len;
                if (len - need >= bta_pkg::MIN_FRAG) begin
                    grant = need;
                    mark(pos + need, len - need, 1'b1);
                end
                mark(pos, grant, 1'b0);
                g.status = bta_pkg::ST_OK;
                g.gidx   = bta_pkg::IDX_W'(pos + 1);
                g.gwords = bta_pkg::LEN_W'(grant);
                return g;
            end
            pos += len;
        end
        return g;
    endfunction

    function automatic t_grant release_frag(logic [bta_pkg::IDX_W-1:0] uidx);
        t_grant g;
        int unsigned head, pos, l, total, llen, right, rlen;
        bit found;
        g = '{status: bta_pkg::ST_OK, gidx: '0, gwords: '0};
        found = 0;
        if (uidx == 0) begin
            g.status = bta_pkg::ST_BADIDX;
            return g;
        end
        head = uidx - 1;
        pos = 0;
        while (pos < pool_eff) begin
            l = tlen(pos);
            if (l == 0) break;
            if (pos == head) begin
                found = 1;
                break;
            end
            pos += l;
        end
        if (!found) begin
            g.status = bta_pkg::ST_BADIDX;
            return g;
        end
        if (tfree(head)) begin
            g.status = bta_pkg::ST_DOUBLE;
            return g;
        end
        total = tlen(head);
        if (head > 0 && tfree(head - 1)) begin
            llen = tlen(head - 1);
            if (llen > 0 && llen <= head) begin
                head -= llen;
                total += llen;
            end
        end
        right = head + total;
        if (right < pool_eff && tfree(right)) begin
            rlen = tlen(right);
            if (rlen > 0 && right + rlen <= pool_eff) total += rlen;
        end
        mark(head, total, 1'b1);
        return g;
    endfunction

    assign o_pending    = grants_due.size();
    assign o_fail_count = fail_count;
    assign o_rsp_count  = rsp_count;

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            rebuild(bta_pkg::LEN_W'(4096));
            grants_due.delete();
        end else begin
            if (i_cfg_we) rebuild(i_cfg_data);
            if (req.valid && req.ready)
                grants_due.push_back(req.kind ? release_frag(req.user_index)
                                              : allocate(req.size_bytes));
            if (rsp.valid && rsp.ready) begin
                rsp_count++;
                if (grants_due.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = grants_due.pop_front();
                    if (rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.granted_index !== want.gidx) begin
                        $error("granted_index: expected %0d, got %0d", want.gidx,
                               rsp.granted_index);
                        fail_count++;
                    end
                    if (rsp.granted_words !== want.gwords) begin
                        $error("granted_words: expected %0d, got %0d", want.gwords,
                               rsp.granted_words);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

/* tb/boundary_tag_first_fit_allocator_tb.sv */
`timescale 1ns / 1ps

module boundary_tag_first_fit_allocator_tb;

    localparam int WATCHDOG = 40000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    int               fails, pending, rsp_count, n_alloc, n_free;
    int               idle_cycles = 0;
    int unsigned      live [$];

    bta_req_if req ();
    bta_rsp_if rsp ();
    bta_cfg_if cfg ();

    boundary_tag_first_fit_allocator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg.we),
        .i_cfg_data (cfg.data),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    bta_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg.we),
        .i_cfg_data   (cfg.data),
        .req          (req),
        .rsp          (rsp),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_rsp_count  (rsp_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // sink side: random stall per word
    initial begin
        int gap;
        rsp.ready <= 1'b0;
        @(posedge clk);
        forever begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) gap = 0;
            repeat (gap) @(posedge clk);
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
            rsp.ready <= 1'b0;
        end
    end

    task automatic send(bit kind, logic [bta_pkg::SIZE_W-1:0] size,
                        logic [bta_pkg::IDX_W-1:0] uidx);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.kind       <= kind;
        req.size_bytes <= size;
        req.user_index <= uidx;
        do @(posedge clk); while (!req.ready);
        if (kind) n_free++; else n_alloc++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_pool(logic [bta_pkg::LEN_W-1:0] words);
        drain();
        cfg.we   <= 1'b1;
        cfg.data <= words;
        @(posedge clk);
        cfg.we <= 1'b0;
        live.delete();
        repeat (4) @(posedge clk);
    endtask

    // random walk: mostly allocates of small sizes and frees of live grants
    task automatic random_phase(int n, int unsigned size_cap);
        int unsigned r, k;
        logic [bta_pkg::IDX_W-1:0] ui;
        logic [bta_pkg::SIZE_W-1:0] sz;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                sz = (r < 3) ? bta_pkg::SIZE_W'($urandom)
                             : bta_pkg::SIZE_W'($urandom_range(0, size_cap));
                send(1'b0, sz, bta_pkg::IDX_W'($urandom));
                req.valid <= 1'b0;
                @(negedge clk);
                while (rsp.valid !== 1'b1 || rsp.ready !== 1'b1) @(negedge clk);
                if (rsp.status == bta_pkg::ST_OK) live.push_back(rsp.granted_index);
                @(posedge clk);
            end else if (r < 85 && live.size() > 0) begin
                k = $urandom_range(0, live.size() - 1);
                ui = bta_pkg::IDX_W'(live[k]);
                // sometimes keep it to provoke a double free later
                if ($urandom_range(0, 9) != 0) live.delete(k);
                send(1'b1, bta_pkg::SIZE_W'($urandom), ui);
            end else begin
                send(1'b1, bta_pkg::SIZE_W'($urandom), bta_pkg::IDX_W'($urandom));
            end
        end
    endtask

    initial begin
        req.valid      <= 1'b0;
        req.kind       <= 1'b0;
        req.size_bytes <= '0;
        req.user_index <= '0;
        cfg.we         <= 1'b0;
        cfg.data       <= '0;
        n_alloc = 0;
        n_free = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed
        send(1'b0, '0, '0);
        send(1'b0, 20'hFFFFF, '1);
        send(1'b0, 20'd1, '0);
        send(1'b0, 20'd4, '0);
        send(1'b0, 20'd5, '0);
        send(1'b1, '1, 12'd0);
        send(1'b1, '0, 12'd2);
        send(1'b1, '0, 12'd4);
        send(1'b1, '0, 12'd4);
        send(1'b1, '0, 12'd1);
        send(1'b1, '0, 12'hFFF);
        send(1'b0, 20'd16376, '0);
        send(1'b0, 20'd16377, '0);
        set_pool(bta_pkg::LEN_W'(2));
        send(1'b0, 20'd1, '0);
        send(1'b0, 20'd1, '0);
        send(1'b1, '0, 12'd1);
        set_pool(bta_pkg::LEN_W'(8));
        send(1'b0, 20'd8, '0);
        send(1'b0, 20'd4, '0);
        send(1'b1, '0, 12'd1);
        send(1'b1, '0, 12'd5);
        set_pool(bta_pkg::LEN_W'(13'h1FFF));
        send(1'b0, 20'd16380, '0);
        send(1'b1, '0, 12'd1);

        set_pool(bta_pkg::LEN_W'(64));
        random_phase(120, 40);
        set_pool(bta_pkg::LEN_W'(4096));
        random_phase(150, 200);
        set_pool(bta_pkg::LEN_W'(3));
        random_phase(30, 8);
        set_pool(bta_pkg::LEN_W'($urandom_range(100, 600)));
        random_phase(200, 120);
        drain();

        $display("covered %0d allocates and %0d frees, %0d result words checked",
                 n_alloc, n_free, rsp_count);
        $display("pool sizes 3, 8, 64, 4096 and clamped 2 and 8191 exercised");
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
